### src/mpmd_pkg.sv
// ----------------------------------------------------------------------------
// mpmd_pkg
// Shared types and constants of the magnetic presence and motion detector.
// ----------------------------------------------------------------------------
package mpmd_pkg;

  localparam int SMOOTHING_SAMPLES_DEF = 4;
  localparam int BASELINE_SAMPLES_DEF  = 16;
  localparam int TRACKING_SAMPLES_DEF  = 256;
  localparam int QUEUE_DEPTH           = 2;

  // configuration register indexes
  localparam logic [2:0] CFG_PRES_THR  = 3'd0;
  localparam logic [2:0] CFG_REL_HYST  = 3'd1;
  localparam logic [2:0] CFG_AXIS      = 3'd2;
  localparam logic [2:0] CFG_INVERT    = 3'd3;
  localparam logic [2:0] CFG_MOT_THR   = 3'd4;
  localparam logic [2:0] CFG_DIR_MIN   = 3'd5;
  localparam logic [2:0] CFG_SETTLE    = 3'd6;

  // status and event bit positions
  localparam int FL_VALID  = 0;
  localparam int FL_CAL    = 1;
  localparam int FL_ACTIVE = 2;
  localparam int FL_MOVING = 3;
  localparam int FL_QUAL   = 4;
  localparam int EV_ACT    = 0;
  localparam int EV_DEACT  = 1;
  localparam int EV_START  = 2;
  localparam int EV_SETTLE = 3;

  localparam logic [2:0] OPC_LOCAL   = 3'd0;
  localparam logic [2:0] OPC_REMOTE  = 3'd1;
  localparam logic [2:0] OPC_INVALID = 3'd2;
  localparam logic [2:0] OPC_RESETCAL = 3'd3;
  localparam logic [2:0] OPC_CAPTURE = 3'd4;
  localparam logic [2:0] OPC_SETBASE = 3'd5;

  typedef enum logic [2:0] {
    OP_LOCAL, OP_REMOTE, OP_INVALID, OP_RESETCAL, OP_CAPTURE, OP_SETBASE, OP_NOP
  } op_e;

  typedef struct packed {
    op_e                op;
    logic signed [23:0] field_x;
    logic signed [23:0] field_y;
    logic signed [23:0] field_z;
    logic [31:0]        time_ms;
    logic signed [7:0]  remote_direction;
    logic               remote_moving;
    logic signed [23:0] remote_velocity;
    logic signed [23:0] new_baseline;
  } item_t;

  typedef struct packed {
    logic signed [23:0] raw_value;
    logic signed [23:0] filtered_value;
    logic signed [23:0] baseline_value;
    logic [23:0]        delta_value;
    logic signed [23:0] velocity_value;
    logic [4:0]         status_bits;
    logic [3:0]         event_bits;
    logic signed [1:0]  motion_direction;
    logic signed [1:0]  settled_direction;
    logic               command_ok;
  } result_t;

  typedef struct packed {
    logic        we;
    logic [2:0]  idx;
    logic [22:0] data;
  } cfg_t;

endpackage

### src/magnetic_presence_motion_detector_unit.sv
// ----------------------------------------------------------------------------
// magnetic_presence_motion_detector_unit
// Presence and motion detection on one axis of a magnetometer stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input items enter through a queue: an item transaction completes when
//   push is high and full is low. Items are samples (local or remote) or
//   commands (invalid, reset calibration, capture, set baseline).
//   Each item yields exactly one result, in order, on the result queue: the
//   oldest result is shown while empty is low and leaves when pop is high.
//   Each item is held in the input queue until the state update takes it,
//   and that state update writes its result into the result queue.
//   Throughput is one item per cycle while the result queue has room and
//   no configuration write is under way.
//   If the receiver stalls, the result queue fills, the state update holds
//   and the input queue backs up until full rises; nothing is dropped.
//   Configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) take effect at
//   once and are meant for idle periods only.
//   Reset clears all state and both queues and loads register defaults.
// ----------------------------------------------------------------------------
module magnetic_presence_motion_detector_unit #(
  parameter int SMOOTHING_SAMPLES = mpmd_pkg::SMOOTHING_SAMPLES_DEF,
  parameter int BASELINE_SAMPLES  = mpmd_pkg::BASELINE_SAMPLES_DEF,
  parameter int TRACKING_SAMPLES  = mpmd_pkg::TRACKING_SAMPLES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [22:0]        cfg_data_i,
  input  logic               push,
  output logic               full,
  input  logic [2:0]         opcode_i,
  input  logic signed [23:0] field_x_i,
  input  logic signed [23:0] field_y_i,
  input  logic signed [23:0] field_z_i,
  input  logic [31:0]        time_ms_i,
  input  logic signed [7:0]  remote_direction_i,
  input  logic               remote_moving_i,
  input  logic signed [23:0] remote_velocity_i,
  input  logic signed [23:0] new_baseline_i,
  output logic               empty,
  input  logic               pop,
  output logic signed [23:0] raw_value_o,
  output logic signed [23:0] filtered_value_o,
  output logic signed [23:0] baseline_value_o,
  output logic [23:0]        delta_value_o,
  output logic signed [23:0] velocity_value_o,
  output logic [4:0]         status_bits_o,
  output logic [3:0]         event_bits_o,
  output logic signed [1:0]  motion_direction_o,
  output logic signed [1:0]  settled_direction_o,
  output logic               command_ok_o
);
  import mpmd_pkg::*;

  cfg_t    cfg;
  item_t   item;
  logic    item_valid, take, res_full;
  result_t res_in, res_out;

  assign cfg.we   = cfg_we_i;
  assign cfg.idx  = cfg_idx_i;
  assign cfg.data = cfg_data_i;

  mpmd_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .push               (push),
    .full               (full),
    .opcode_i           (opcode_i),
    .field_x_i          (field_x_i),
    .field_y_i          (field_y_i),
    .field_z_i          (field_z_i),
    .time_ms_i          (time_ms_i),
    .remote_direction_i (remote_direction_i),
    .remote_moving_i    (remote_moving_i),
    .remote_velocity_i  (remote_velocity_i),
    .new_baseline_i     (new_baseline_i),
    .take_i             (take),
    .item_o             (item),
    .item_valid_o       (item_valid)
  );

  mpmd_back #(
    .SMOOTHING_SAMPLES (SMOOTHING_SAMPLES),
    .BASELINE_SAMPLES  (BASELINE_SAMPLES),
    .TRACKING_SAMPLES  (TRACKING_SAMPLES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_i       (item),
    .item_valid_i (item_valid),
    .res_full_i   (res_full),
    .take_o       (take),
    .res_o        (res_in)
  );

  mpmd_fifo #(.WIDTH($bits(result_t)), .DEPTH(QUEUE_DEPTH)) u_resq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (take),
    .wdata_i (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_out),
    .empty_o (empty)
  );

  assign raw_value_o         = res_out.raw_value;
  assign filtered_value_o    = res_out.filtered_value;
  assign baseline_value_o    = res_out.baseline_value;
  assign delta_value_o       = res_out.delta_value;
  assign velocity_value_o    = res_out.velocity_value;
  assign status_bits_o       = res_out.status_bits;
  assign event_bits_o        = res_out.event_bits;
  assign motion_direction_o  = res_out.motion_direction;
  assign settled_direction_o = res_out.settled_direction;
  assign command_ok_o        = res_out.command_ok;

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |-> !res_full) else $error("result queue overrun");
  a_active_needs_cal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (!status_bits_o[FL_ACTIVE] ||
                (status_bits_o[FL_VALID] && status_bits_o[FL_CAL])))
    else $error("active without valid calibrated data");
  a_take_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |-> item_valid && !cfg_we_i) else $error("item taken from empty queue");
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && empty |=> !empty) else $error("result lost");
`endif
endmodule

### src/mpmd_fifo.sv
// ----------------------------------------------------------------------------
// mpmd_fifo
// Small first-in first-out queue of register entries.
// ----------------------------------------------------------------------------
module mpmd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end
endmodule

### src/mpmd_front.sv
// ----------------------------------------------------------------------------
// mpmd_front
// Accepts input transactions, classifies the opcode and queues the items.
// ----------------------------------------------------------------------------
module mpmd_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  logic [2:0]            opcode_i,
  input  logic signed [23:0]    field_x_i,
  input  logic signed [23:0]    field_y_i,
  input  logic signed [23:0]    field_z_i,
  input  logic [31:0]           time_ms_i,
  input  logic signed [7:0]     remote_direction_i,
  input  logic                  remote_moving_i,
  input  logic signed [23:0]    remote_velocity_i,
  input  logic signed [23:0]    new_baseline_i,
  input  logic                  take_i,
  output mpmd_pkg::item_t       item_o,
  output logic                  item_valid_o
);
  import mpmd_pkg::*;

  item_t item;
  logic  empty;

  always_comb begin
    case (opcode_i)
      OPC_LOCAL:    item.op = OP_LOCAL;
      OPC_REMOTE:   item.op = OP_REMOTE;
      OPC_INVALID:  item.op = OP_INVALID;
      OPC_RESETCAL: item.op = OP_RESETCAL;
      OPC_CAPTURE:  item.op = OP_CAPTURE;
      OPC_SETBASE:  item.op = OP_SETBASE;
      default:      item.op = OP_NOP;
    endcase
    item.field_x          = field_x_i;
    item.field_y          = field_y_i;
    item.field_z          = field_z_i;
    item.time_ms          = time_ms_i;
    item.remote_direction = remote_direction_i;
    item.remote_moving    = remote_moving_i;
    item.remote_velocity  = remote_velocity_i;
    item.new_baseline     = new_baseline_i;
  end

  mpmd_fifo #(.WIDTH($bits(item_t)), .DEPTH(QUEUE_DEPTH)) u_inq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (item),
    .full_o  (full),
    .pop_i   (take_i),
    .rdata_o (item_o),
    .empty_o (empty)
  );

  assign item_valid_o = !empty;
endmodule

### src/mpmd_back.sv
// ----------------------------------------------------------------------------
// mpmd_back
// Holds detector state, carries out one queued item per cycle unless stalled.
// ----------------------------------------------------------------------------
module mpmd_back #(
  parameter int SMOOTHING_SAMPLES = mpmd_pkg::SMOOTHING_SAMPLES_DEF,
  parameter int BASELINE_SAMPLES  = mpmd_pkg::BASELINE_SAMPLES_DEF,
  parameter int TRACKING_SAMPLES  = mpmd_pkg::TRACKING_SAMPLES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mpmd_pkg::cfg_t    cfg_i,
  input  mpmd_pkg::item_t   item_i,
  input  logic              item_valid_i,
  input  logic              res_full_i,
  output logic              take_o,
  output mpmd_pkg::result_t res_o
);
  import mpmd_pkg::*;

  localparam logic signed [32:0] SmoothDiv = 33'(SMOOTHING_SAMPLES);
  localparam logic signed [39:0] BaseDiv   = 40'(BASELINE_SAMPLES);
  localparam logic signed [32:0] TrackDiv  = 33'(TRACKING_SAMPLES);
  localparam logic [7:0]         BaseCnt   = 8'(BASELINE_SAMPLES);

  typedef struct packed {
    logic        active;
    logic [23:0] dq8;
    logic        ev_act;
    logic        ev_deact;
  } pres_t;

  function automatic pres_t presence(logic valid, logic cal, logic was,
                                     logic signed [31:0] f, logic signed [31:0] b,
                                     logic [22:0] thr, logic [22:0] hyst);
    pres_t              r;
    logic signed [32:0] diff;
    logic [32:0]        magn;
    logic [22:0]        sens;
    logic signed [23:0] rel;
    logic               nxt;
    r    = '0;
    diff = 33'(f) - 33'(b);
    magn = diff[32] ? 33'(-diff) : 33'(diff);
    sens = (thr < 23'd256) ? 23'd256 : thr;
    rel  = $signed({1'b0, sens}) - $signed({1'b0, hyst});
    if (rel < 24'sd128) begin
      rel = 24'sd128;
    end
    nxt = was ? (magn >= {2'b0, rel[22:0], 8'b0}) : (magn >= {2'b0, sens, 8'b0});
    if (valid && cal) begin
      r.active   = nxt;
      r.dq8      = magn[32] ? 24'hFFFFFF : magn[31:8];
      r.ev_act   = !was && nxt;
      r.ev_deact = was && !nxt;
    end
    return r;
  endfunction

  logic [22:0]        thr_q, thr_d, hyst_q, hyst_d, mthr_q, mthr_d, dmin_q, dmin_d;
  logic [1:0]         axis_q, axis_d;
  logic               inv_q, inv_d;
  logic [15:0]        settle_q, settle_d;
  logic signed [31:0] f_q, f_d, b_q, b_d, pf_q, pf_d, msv_q, msv_d;
  logic               hs_q, hs_d, hp_q, hp_d;
  logic signed [39:0] sum_q, sum_d;
  logic [7:0]         cnt_q, cnt_d;
  logic [4:0]         fl_q, fl_d;
  logic signed [1:0]  dir_q, dir_d, sd_q, sd_d;
  logic [31:0]        lmt_q, lmt_d;
  logic signed [23:0] raw_q, raw_d, vel_q, vel_d;
  logic [23:0]        dq_q, dq_d;
  logic [3:0]         ev_q, ev_d;
  logic               ok;

  assign take_o = item_valid_i && !res_full_i && !cfg_i.we;

  always_comb begin
    pres_t              p;
    logic signed [23:0] raw;
    logic signed [31:0] raw256;
    logic signed [32:0] v, chg;
    logic signed [24:0] vq;
    logic [32:0]        vmag, cmag;
    logic [22:0]        mt, dm;
    logic [15:0]        st;
    logic               meaningful, settled, was, do_pres;
    logic signed [1:0]  d, sdir, prev;
    logic [31:0]        now;

    thr_d = thr_q; hyst_d = hyst_q; axis_d = axis_q; inv_d = inv_q;
    mthr_d = mthr_q; dmin_d = dmin_q; settle_d = settle_q;
    f_d = f_q; b_d = b_q; pf_d = pf_q; msv_d = msv_q;
    hs_d = hs_q; hp_d = hp_q; sum_d = sum_q; cnt_d = cnt_q; fl_d = fl_q;
    dir_d = dir_q; sd_d = sd_q; lmt_d = lmt_q;
    raw_d = raw_q; vel_d = vel_q; dq_d = dq_q; ev_d = ev_q;
    ok = 1'b1; do_pres = 1'b0; p = '0;
    raw = '0; raw256 = '0; v = '0; chg = '0; vq = '0; vmag = '0; cmag = '0;
    meaningful = 1'b0; settled = 1'b0; was = 1'b0; d = '0; sdir = '0; prev = '0;
    now = item_i.time_ms;
    mt = (mthr_q < 23'd26) ? 23'd26 : mthr_q;
    dm = (dmin_q < 23'd26) ? 23'd26 : dmin_q;
    st = (settle_q < 16'd100) ? 16'd100 : settle_q;

    if (cfg_i.we) begin
      case (cfg_i.idx)
        CFG_PRES_THR: begin
          thr_d   = cfg_i.data;
          do_pres = 1'b1;
        end
        CFG_REL_HYST: hyst_d = cfg_i.data;
        CFG_AXIS: begin
          if (cfg_i.data[1:0] != axis_q) begin
            axis_d = cfg_i.data[1:0];
            hs_d = 1'b0; hp_d = 1'b0;
            fl_d[FL_CAL] = 1'b0; fl_d[FL_ACTIVE] = 1'b0;
            fl_d[FL_MOVING] = 1'b0; fl_d[FL_QUAL] = 1'b0;
            b_d = '0; dq_d = '0; ev_d = '0; sd_d = '0; dir_d = '0;
            sum_d = '0; cnt_d = '0;
          end
        end
        CFG_INVERT:  inv_d    = cfg_i.data[0];
        CFG_MOT_THR: mthr_d   = cfg_i.data;
        CFG_DIR_MIN: dmin_d   = cfg_i.data;
        CFG_SETTLE:  settle_d = cfg_i.data[15:0];
        default: ;
      endcase
    end else if (take_o) begin
      if (item_i.op == OP_LOCAL || item_i.op == OP_REMOTE) begin
        case (axis_q)
          2'd0:    raw = item_i.field_x;
          2'd1:    raw = item_i.field_y;
          2'd2:    raw = item_i.field_z;
          default: raw = '0;
        endcase
        raw256 = {raw, 8'b0};
        f_d = hs_q ? f_q + 32'((33'(raw256) - 33'(f_q)) / SmoothDiv) : raw256;
        hs_d = 1'b1;
        raw_d = raw;
        fl_d[FL_VALID] = 1'b1;
        if (!fl_q[FL_CAL]) begin
          sum_d = sum_q + 40'(f_d);
          cnt_d = cnt_q + 8'd1;
          if (cnt_d >= BaseCnt && cnt_d != 8'd0) begin
            b_d = 32'(sum_d / BaseDiv);
            fl_d[FL_CAL] = 1'b1;
          end
        end else if (!fl_q[FL_ACTIVE] && !fl_q[FL_MOVING]) begin
          b_d = b_q + 32'((33'(f_d) - 33'(b_q)) / TrackDiv);
        end
        p = presence(1'b1, fl_d[FL_CAL], fl_d[FL_ACTIVE], f_d, b_d, thr_q, hyst_q);
        fl_d[FL_ACTIVE] = p.active;
        dq_d = p.dq8;
        ev_d[EV_ACT] = p.ev_act;
        ev_d[EV_DEACT] = p.ev_deact;
        ev_d[EV_START] = 1'b0;
        ev_d[EV_SETTLE] = 1'b0;
        sd_d = '0;

        if (item_i.op == OP_LOCAL) begin
          if (!hp_q) begin
            pf_d = f_d; hp_d = 1'b1; vel_d = '0;
          end else begin
            v = 33'(f_d) - 33'(pf_q);
            pf_d = f_d;
            vq = 25'(v >>> 8);
            if (vq > 25'sd8388607) vel_d = 24'sh7FFFFF;
            else if (vq < -25'sd8388608) vel_d = 24'sh800000;
            else vel_d = vq[23:0];
            vmag = v[32] ? 33'(-v) : 33'(v);
            meaningful = vmag >= {2'b0, mt, 8'b0};
            if (!fl_d[FL_MOVING] && meaningful) begin
              fl_d[FL_MOVING] = 1'b1;
              fl_d[FL_QUAL] = fl_d[FL_ACTIVE];
              msv_d = pf_q;
              lmt_d = now;
              ev_d[EV_START] = 1'b1;
            end
            if (fl_d[FL_MOVING]) begin
              if (fl_d[FL_ACTIVE]) fl_d[FL_QUAL] = 1'b1;
              if (meaningful) lmt_d = now;
              chg = 33'(f_d) - 33'(msv_d);
              cmag = chg[32] ? 33'(-chg) : 33'(chg);
              if (cmag < {2'b0, dm, 8'b0}) d = 2'sd0;
              else d = ((chg > 0) != inv_q) ? 2'sd1 : -2'sd1;
              if (d != 2'sd0) dir_d = d;
              if ((now - lmt_d) >= 32'(st)) begin
                sdir = (d != 2'sd0) ? d : dir_d;
                fl_d[FL_MOVING] = 1'b0;
                settled = fl_d[FL_QUAL] && (sdir != 2'sd0);
                if (settled) begin
                  ev_d[EV_SETTLE] = 1'b1;
                  sd_d = sdir;
                end
              end
            end
          end
          if (!fl_d[FL_MOVING] && !settled) begin
            dir_d = '0;
            fl_d[FL_QUAL] = 1'b0;
          end
        end else begin
          was = fl_d[FL_MOVING];
          prev = dir_q;
          if (item_i.remote_direction > 8'sd1) d = 2'sd1;
          else if (item_i.remote_direction < -8'sd1) d = -2'sd1;
          else d = item_i.remote_direction[1:0];
          if (inv_q) d = -d;
          vel_d = item_i.remote_velocity;
          if (item_i.remote_moving) begin
            fl_d[FL_MOVING] = 1'b1;
            if (!was) fl_d[FL_QUAL] = fl_d[FL_ACTIVE];
            if (fl_d[FL_ACTIVE]) fl_d[FL_QUAL] = 1'b1;
            if (!was) ev_d[EV_START] = 1'b1;
            if (d != 2'sd0) dir_d = d;
          end else begin
            if (was && fl_d[FL_QUAL] && prev != 2'sd0) begin
              ev_d[EV_SETTLE] = 1'b1;
              sd_d = prev;
            end
            fl_d[FL_MOVING] = 1'b0;
            fl_d[FL_QUAL] = 1'b0;
            dir_d = '0;
          end
        end
      end else begin
        case (item_i.op)
          OP_INVALID: begin
            ev_d = '0;
            ev_d[EV_DEACT] = fl_q[FL_ACTIVE];
            fl_d[FL_VALID] = 1'b0; fl_d[FL_ACTIVE] = 1'b0;
            fl_d[FL_MOVING] = 1'b0; fl_d[FL_QUAL] = 1'b0;
            dq_d = '0; sd_d = '0; dir_d = '0;
          end
          OP_RESETCAL: begin
            fl_d[FL_CAL] = 1'b0; fl_d[FL_ACTIVE] = 1'b0;
            fl_d[FL_MOVING] = 1'b0; fl_d[FL_QUAL] = 1'b0;
            b_d = '0; dq_d = '0; ev_d = '0; sd_d = '0; dir_d = '0;
            sum_d = '0; cnt_d = '0;
          end
          OP_CAPTURE: begin
            if (!hs_q) begin
              ok = 1'b0;
            end else begin
              b_d = f_q; fl_d[FL_CAL] = 1'b1; sum_d = '0; cnt_d = BaseCnt;
              do_pres = 1'b1;
            end
          end
          OP_SETBASE: begin
            b_d = {item_i.new_baseline, 8'b0};
            fl_d[FL_CAL] = 1'b1; sum_d = '0; cnt_d = BaseCnt;
            do_pres = 1'b1;
          end
          default: ;
        endcase
      end
    end

    // re-evaluate presence after a threshold write, a baseline capture or a set baseline
    if (do_pres) begin
      p = presence(fl_d[FL_VALID], fl_d[FL_CAL], fl_d[FL_ACTIVE], f_d, b_d, thr_d, hyst_d);
      fl_d[FL_ACTIVE] = p.active;
      dq_d = p.dq8;
      ev_d[EV_ACT] = p.ev_act;
      ev_d[EV_DEACT] = p.ev_deact;
    end

    res_o.raw_value         = raw_d;
    res_o.filtered_value    = f_d[31:8];
    res_o.baseline_value    = b_d[31:8];
    res_o.delta_value       = dq_d;
    res_o.velocity_value    = vel_d;
    res_o.status_bits       = fl_d;
    res_o.event_bits        = ev_d;
    res_o.motion_direction  = dir_d;
    res_o.settled_direction = sd_d;
    res_o.command_ok        = ok;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= 23'd1280; hyst_q <= 23'd256; axis_q <= 2'd2; inv_q <= 1'b0;
      mthr_q <= 23'd128; dmin_q <= 23'd256; settle_q <= 16'd500;
      f_q <= '0; b_q <= '0; pf_q <= '0; msv_q <= '0;
      hs_q <= 1'b0; hp_q <= 1'b0; sum_q <= '0; cnt_q <= '0; fl_q <= '0;
      dir_q <= '0; sd_q <= '0; lmt_q <= '0;
      raw_q <= '0; vel_q <= '0; dq_q <= '0; ev_q <= '0;
    end else begin
      thr_q <= thr_d; hyst_q <= hyst_d; axis_q <= axis_d; inv_q <= inv_d;
      mthr_q <= mthr_d; dmin_q <= dmin_d; settle_q <= settle_d;
      f_q <= f_d; b_q <= b_d; pf_q <= pf_d; msv_q <= msv_d;
      hs_q <= hs_d; hp_q <= hp_d; sum_q <= sum_d; cnt_q <= cnt_d; fl_q <= fl_d;
      dir_q <= dir_d; sd_q <= sd_d; lmt_q <= lmt_d;
      raw_q <= raw_d; vel_q <= vel_d; dq_q <= dq_d; ev_q <= ev_d;
    end
  end
endmodule
